/* rtl/core/tcg_pkg.sv */
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared constants, register indexes and the 6x8 font for the text
// character generator.
// ----------------------------------------------------------------------------
package tcg_pkg;

  localparam int CODE_W      = 21;
  localparam int ORIGIN_W    = 16;
  localparam int ROW_W       = 3;
  localparam int PIX_W       = 6;
  localparam int COLOR_W     = 32;
  localparam int SCALE_W     = 6;
  localparam int FALLBACK_W  = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int GLYPH_BITS  = 48;
  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_IDX_W = 7;
  localparam int GLYPH_ROWS  = 8;

  localparam int DEF_MAX_COLUMNS = 256;
  localparam int DEF_MAX_LINES   = 64;
  localparam int DEF_LINE_PITCH  = 10;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INK_COLOR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_CODE = 2'd2;

  localparam logic [CODE_W-1:0] CODE_NEWLINE = 21'd10;
  localparam logic [CODE_W-1:0] CODE_TAB     = 21'd9;

  localparam logic [FALLBACK_W-1:0] FIRST_CODE    = 7'd32;
  localparam logic [FALLBACK_W-1:0] DEFAULT_FB    = 7'd63;
  localparam logic [SCALE_W-1:0]    SCALE_MAX     = 6'd32;
  localparam logic [SCALE_W-1:0]    SCALE_RESET   = 6'd2;
  localparam logic [COLOR_W-1:0]    INK_RESET     = 32'hFFFF_FFFF;
  localparam int                    TAB_ADVANCE   = 4;
  localparam int                    GLYPH_W       = 6;

  // one entry per glyph, eight 6-bit rows, top row in bits 47:42
  localparam logic [GLYPH_BITS-1:0] FONT_ROM [GLYPH_COUNT] = '{
    48'h000000000000, 48'h10E384100100, 48'h6DB480000000, 48'h00A7CA29F280,
    48'h20E40C09C100, 48'h6590842134C0, 48'h214508552340, 48'h30C200000000,
    48'h108208208100, 48'h204104104200, 48'h00A39F38A000, 48'h00411F104000,
    48'h00000000C308, 48'h00001F000000, 48'h00000000C300, 48'h001084210000,
    48'h3914D5651380, 48'h10C104104380, 48'h3910462107C0, 48'h39104E051380,
    48'h0862927C2080, 48'h7D041E051380, 48'h18841E451380, 48'h7C1084208200,
    48'h39144E451380, 48'h39144F042300, 48'h00030C00C300, 48'h00030C00C308,
    48'h084210204080, 48'h0007C001F000, 48'h204081084200, 48'h391046100100,
    48'h3915D55D0380, 48'h3914517D1440, 48'h79145E451780, 48'h391410411380,
    48'h791451451780, 48'h7D041E4107C0, 48'h7D041E410400, 48'h3914174513C0,
    48'h45145F451440, 48'h384104104380, 48'h041041451380, 48'h452518512440,
    48'h4104104107C0, 48'h45B551451440, 48'h459553451440, 48'h391451451380,
    48'h79145E410400, 48'h391451552340, 48'h79145E491440, 48'h39140E051380,
    48'h7C4104104100, 48'h451451451380, 48'h45145144A100, 48'h451555555280,
    48'h451284291440, 48'h45144A104100, 48'h782108410780, 48'h388208208380,
    48'h010204081000, 48'h382082082380, 48'h10A440000000, 48'h00000000003F,
    48'h30C100000000, 48'h0003813D13C0, 48'h410791451780, 48'h000391411380,
    48'h0413D14513C0, 48'h000391790380, 48'h18821E208200, 48'h0003D144F04E,
    48'h410712492480, 48'h100104104180, 48'h08018208248C, 48'h410494614480,
    48'h104104104180, 48'h000695551440, 48'h000712492480, 48'h000391451380,
    48'h000791451790, 48'h0003D14513C1, 48'h000589208700, 48'h000390381380,
    48'h00878820A100, 48'h000492496280, 48'h00045144A100, 48'h00045155F280,
    48'h000492312480, 48'h00049248E118, 48'h000782310780, 48'h188218208180,
    48'h104100104100, 48'h302083082300, 48'h294000000000, 48'h10E6D145F000
  };

endpackage

/* rtl/core/tcg_ram.sv */
// ----------------------------------------------------------------------------
// tcg_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/text_character_generator_top.sv */
// ----------------------------------------------------------------------------
// text_character_generator_top
// Text cursor and 6x8 glyph row generator.
// ----------------------------------------------------------------------------
// Each item other than newline and tab produces eight result items, one per
// cycle while out_stall is low, top row first, from the single output glyph
// register set. Newline and tab move the cursor in the cycle they are accepted
// and produce nothing. Accepted glyphs (origin and font bits) wait in a RAM
// queue of QUEUE_DEPTH entries; the input stalls only while that queue is
// full, so items keep being accepted while rows are still going out. A glyph
// passes through the queue RAM and its registered read data into the output
// glyph registers. QUEUE_DEPTH must be a power of two, at least 2.
module text_character_generator_top #(
  parameter int MAX_COLUMNS = tcg_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_LINES   = tcg_pkg::DEF_MAX_LINES,
  parameter int LINE_PITCH  = tcg_pkg::DEF_LINE_PITCH,
  parameter int QUEUE_DEPTH = tcg_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tcg_pkg::CODE_W-1:0]       in_code_point,
  input  logic                             in_text_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tcg_pkg::ORIGIN_W-1:0]     out_origin_x,
  output logic [tcg_pkg::ORIGIN_W-1:0]     out_origin_y,
  output logic [tcg_pkg::ROW_W-1:0]        out_glyph_row,
  output logic [tcg_pkg::PIX_W-1:0]        out_row_pixels,
  output logic [tcg_pkg::COLOR_W-1:0]      out_pixel_color,
  output logic                             out_last_row
);

  import tcg_pkg::*;

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int XSTEP_W = $clog2(GLYPH_W * 32 + 1);
  localparam int YSTEP_W = $clog2(LINE_PITCH * 32 + 1);
  localparam int XP_W    = COL_W + XSTEP_W;
  localparam int YP_W    = LINE_W + YSTEP_W;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int Q_W     = 2 * ORIGIN_W + GLYPH_BITS;
  localparam int ORIGIN_MAX_V = (1 << ORIGIN_W) - 1;

  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(MAX_COLUMNS - 1);
  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(MAX_LINES - 1);
  localparam logic [CNT_W-1:0]  Q_FULL    = CNT_W'(QUEUE_DEPTH);

  // configuration
  logic [XSTEP_W-1:0]    x_step_r, x_step_nxt;
  logic [YSTEP_W-1:0]    y_step_r, y_step_nxt;
  logic [COLOR_W-1:0]    ink_r;
  logic [FALLBACK_W-1:0] fb_r;
  logic [SCALE_W-1:0]    scale_eff;

  // cursor
  logic [COL_W-1:0]  col_r, col_nxt, col_base;
  logic [LINE_W-1:0] line_r, line_nxt, line_base;
  logic [COL_W:0]    col_tab;

  // queue
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             q_we, q_re;
  logic [Q_W-1:0]   q_wdata, q_rdata;
  logic             pend_r, pend_nxt;

  // glyph being emitted
  logic                  cur_valid_r, cur_valid_nxt;
  logic [ORIGIN_W-1:0]   cur_x_r, cur_y_r;
  logic [GLYPH_BITS-1:0] cur_bits_r;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic                  cur_done, load_cur;
  logic [PIX_W-1:0]      row_sel [GLYPH_ROWS];

  // item decode
  logic                   in_acc, is_nl, is_tab, is_print_range;
  logic [FALLBACK_W-1:0]  fb_eff, code_eff;
  logic [GLYPH_IDX_W-1:0] glyph_idx;
  logic [XP_W-1:0]        x_prod;
  logic [YP_W-1:0]        y_prod;
  logic [31:0]            x_wide, y_wide;
  logic [ORIGIN_W-1:0]    ox, oy;

  always_comb begin
    scale_eff = cfg_wdata[SCALE_W-1:0];
    if (scale_eff == '0) begin
      scale_eff = SCALE_W'(1);
    end else if (scale_eff > SCALE_MAX) begin
      scale_eff = SCALE_MAX;
    end
    x_step_nxt = XSTEP_W'({scale_eff, 2'b00}) + XSTEP_W'({scale_eff, 1'b0});
    y_step_nxt = YSTEP_W'(int'(scale_eff) * LINE_PITCH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_step_r <= XSTEP_W'(GLYPH_W * int'(SCALE_RESET));
      y_step_r <= YSTEP_W'(LINE_PITCH * int'(SCALE_RESET));
      ink_r    <= INK_RESET;
      fb_r     <= DEFAULT_FB;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GLYPH_SCALE: begin
          x_step_r <= x_step_nxt;
          y_step_r <= y_step_nxt;
        end
        CFG_INK_COLOR: begin
          ink_r <= cfg_wdata[COLOR_W-1:0];
        end
        CFG_FALLBACK_CODE: begin
          fb_r <= cfg_wdata[FALLBACK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input side: cursor update, origin, font lookup
  assign in_stall = (cnt_r == Q_FULL);
  assign in_acc   = in_valid && !in_stall;
  assign is_nl    = (in_code_point == CODE_NEWLINE);
  assign is_tab   = (in_code_point == CODE_TAB);
  assign is_print_range = (in_code_point[CODE_W-1:FALLBACK_W] == '0) &&
                          (in_code_point[FALLBACK_W-1:0] >= FIRST_CODE);

  assign fb_eff    = (fb_r < FIRST_CODE) ? DEFAULT_FB : fb_r;
  assign code_eff  = is_print_range ? in_code_point[FALLBACK_W-1:0] : fb_eff;
  assign glyph_idx = code_eff - FIRST_CODE;

  assign col_base  = in_text_start ? '0 : col_r;
  assign line_base = in_text_start ? '0 : line_r;
  assign col_tab   = {1'b0, col_base} + (COL_W + 1)'(TAB_ADVANCE);

  always_comb begin
    col_nxt  = col_base;
    line_nxt = line_base;
    if (is_nl) begin
      col_nxt = '0;
      if (line_base < LINE_LAST) begin
        line_nxt = line_base + LINE_W'(1);
      end
    end else if (is_tab) begin
      col_nxt = (col_tab > {1'b0, COL_LAST}) ? COL_LAST : col_tab[COL_W-1:0];
    end else if (col_base < COL_LAST) begin
      col_nxt = col_base + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
    end else if (in_acc) begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

  assign x_prod = XP_W'(col_base) * XP_W'(x_step_r);
  assign y_prod = YP_W'(line_base) * YP_W'(y_step_r);
  assign x_wide = 32'(x_prod);
  assign y_wide = 32'(y_prod);
  assign ox = (x_wide > 32'(ORIGIN_MAX_V)) ? ORIGIN_W'(ORIGIN_MAX_V) : x_wide[ORIGIN_W-1:0];
  assign oy = (y_wide > 32'(ORIGIN_MAX_V)) ? ORIGIN_W'(ORIGIN_MAX_V) : y_wide[ORIGIN_W-1:0];

  // glyph queue; a write never hits the entry being read since the queue is
  // never written while full and read only while not empty
  assign q_we    = in_acc && !is_nl && !is_tab;
  assign q_wdata = {ox, oy, FONT_ROM[glyph_idx]};

  assign cur_done = cur_valid_r && !out_stall && (row_r == ROW_W'(GLYPH_ROWS - 1));
  assign load_cur = pend_r && (!cur_valid_r || cur_done);
  assign q_re     = (cnt_r != '0) && (!pend_r || load_cur);

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_we && !q_re) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!q_we && q_re) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (q_re) begin
      pend_nxt = 1'b1;
    end else if (load_cur) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  tcg_ram #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (wr_ptr_r),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (rd_ptr_r),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
    end else begin
      if (q_we) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (q_re) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  // output side: one row per cycle while out_stall is low
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    row_nxt       = row_r;
    if (load_cur) begin
      cur_valid_nxt = 1'b1;
      row_nxt       = '0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (cur_valid_r && !out_stall) begin
      row_nxt = row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      row_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      row_r       <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      {cur_x_r, cur_y_r, cur_bits_r} <= q_rdata;
    end
  end

  for (genvar i = 0; i < GLYPH_ROWS; i++) begin : g_rows
    assign row_sel[i] = cur_bits_r[GLYPH_BITS-1-PIX_W*i -: PIX_W];
  end

  assign out_valid       = cur_valid_r;
  assign out_origin_x    = cur_x_r;
  assign out_origin_y    = cur_y_r;
  assign out_glyph_row   = row_r;
  assign out_row_pixels  = row_sel[row_r];
  assign out_pixel_color = ink_r;
  assign out_last_row    = (row_r == ROW_W'(GLYPH_ROWS - 1));

endmodule
